[rtl/core/sm4_pkg.sv]
// SM4 package: item kinds, S-box table, round function helpers.
// No dependencies; used by every module of the SM4 core.
`default_nettype none
package sm4_pkg;
    localparam int ROUNDS   = 32;
    localparam int KEY_AW   = 5;

    typedef enum logic [1:0] {
        KIND_LOAD = 2'd0,
        KIND_ENC  = 2'd1,
        KIND_DEC  = 2'd2,
        KIND_NONE = 2'd3
    } t_kind;

    typedef struct packed {
        logic        dec;
        logic [31:0] x0;
        logic [31:0] x1;
        logic [31:0] x2;
        logic [31:0] x3;
    } t_state;

    function automatic logic [7:0] sbox(input logic [7:0] a);
        logic [7:0] r;
        case (a)
            8'h00: r=8'hd6; 8'h01: r=8'h90; 8'h02: r=8'he9; 8'h03: r=8'hfe;
            8'h04: r=8'hcc; 8'h05: r=8'he1; 8'h06: r=8'h3d; 8'h07: r=8'hb7;
            8'h08: r=8'h16; 8'h09: r=8'hb6; 8'h0a: r=8'h14; 8'h0b: r=8'hc2;
            8'h0c: r=8'h28; 8'h0d: r=8'hfb; 8'h0e: r=8'h2c; 8'h0f: r=8'h05;
            8'h10: r=8'h2b; 8'h11: r=8'h67; 8'h12: r=8'h9a; 8'h13: r=8'h76;
            8'h14: r=8'h2a; 8'h15: r=8'hbe; 8'h16: r=8'h04; 8'h17: r=8'hc3;
            8'h18: r=8'haa; 8'h19: r=8'h44; 8'h1a: r=8'h13; 8'h1b: r=8'h26;
            8'h1c: r=8'h49; 8'h1d: r=8'h86; 8'h1e: r=8'h06; 8'h1f: r=8'h99;
            8'h20: r=8'h9c; 8'h21: r=8'h42; 8'h22: r=8'h50; 8'h23: r=8'hf4;
            8'h24: r=8'h91; 8'h25: r=8'hef; 8'h26: r=8'h98; 8'h27: r=8'h7a;
            8'h28: r=8'h33; 8'h29: r=8'h54; 8'h2a: r=8'h0b; 8'h2b: r=8'h43;
            8'h2c: r=8'hed; 8'h2d: r=8'hcf; 8'h2e: r=8'hac; 8'h2f: r=8'h62;
            8'h30: r=8'he4; 8'h31: r=8'hb3; 8'h32: r=8'h1c; 8'h33: r=8'ha9;
            8'h34: r=8'hc9; 8'h35: r=8'h08; 8'h36: r=8'he8; 8'h37: r=8'h95;
            8'h38: r=8'h80; 8'h39: r=8'hdf; 8'h3a: r=8'h94; 8'h3b: r=8'hfa;
            8'h3c: r=8'h75; 8'h3d: r=8'h8f; 8'h3e: r=8'h3f; 8'h3f: r=8'ha6;
            8'h40: r=8'h47; 8'h41: r=8'h07; 8'h42: r=8'ha7; 8'h43: r=8'hfc;
            8'h44: r=8'hf3; 8'h45: r=8'h73; 8'h46: r=8'h17; 8'h47: r=8'hba;
            8'h48: r=8'h83; 8'h49: r=8'h59; 8'h4a: r=8'h3c; 8'h4b: r=8'h19;
            8'h4c: r=8'he6; 8'h4d: r=8'h85; 8'h4e: r=8'h4f; 8'h4f: r=8'ha8;
            8'h50: r=8'h68; 8'h51: r=8'h6b; 8'h52: r=8'h81; 8'h53: r=8'hb2;
            8'h54: r=8'h71; 8'h55: r=8'h64; 8'h56: r=8'hda; 8'h57: r=8'h8b;
            8'h58: r=8'hf8; 8'h59: r=8'heb; 8'h5a: r=8'h0f; 8'h5b: r=8'h4b;
            8'h5c: r=8'h70; 8'h5d: r=8'h56; 8'h5e: r=8'h9d; 8'h5f: r=8'h35;
            8'h60: r=8'h1e; 8'h61: r=8'h24; 8'h62: r=8'h0e; 8'h63: r=8'h5e;
            8'h64: r=8'h63; 8'h65: r=8'h58; 8'h66: r=8'hd1; 8'h67: r=8'ha2;
            8'h68: r=8'h25; 8'h69: r=8'h22; 8'h6a: r=8'h7c; 8'h6b: r=8'h3b;
            8'h6c: r=8'h01; 8'h6d: r=8'h21; 8'h6e: r=8'h78; 8'h6f: r=8'h87;
            8'h70: r=8'hd4; 8'h71: r=8'h00; 8'h72: r=8'h46; 8'h73: r=8'h57;
            8'h74: r=8'h9f; 8'h75: r=8'hd3; 8'h76: r=8'h27; 8'h77: r=8'h52;
            8'h78: r=8'h4c; 8'h79: r=8'h36; 8'h7a: r=8'h02; 8'h7b: r=8'he7;
            8'h7c: r=8'ha0; 8'h7d: r=8'hc4; 8'h7e: r=8'hc8; 8'h7f: r=8'h9e;
            8'h80: r=8'hea; 8'h81: r=8'hbf; 8'h82: r=8'h8a; 8'h83: r=8'hd2;
            8'h84: r=8'h40; 8'h85: r=8'hc7; 8'h86: r=8'h38; 8'h87: r=8'hb5;
            8'h88: r=8'ha3; 8'h89: r=8'hf7; 8'h8a: r=8'hf2; 8'h8b: r=8'hce;
            8'h8c: r=8'hf9; 8'h8d: r=8'h61; 8'h8e: r=8'h15; 8'h8f: r=8'ha1;
            8'h90: r=8'he0; 8'h91: r=8'hae; 8'h92: r=8'h5d; 8'h93: r=8'ha4;
            8'h94: r=8'h9b; 8'h95: r=8'h34; 8'h96: r=8'h1a; 8'h97: r=8'h55;
            8'h98: r=8'had; 8'h99: r=8'h93; 8'h9a: r=8'h32; 8'h9b: r=8'h30;
            8'h9c: r=8'hf5; 8'h9d: r=8'h8c; 8'h9e: r=8'hb1; 8'h9f: r=8'he3;
            8'ha0: r=8'h1d; 8'ha1: r=8'hf6; 8'ha2: r=8'he2; 8'ha3: r=8'h2e;
            8'ha4: r=8'h82; 8'ha5: r=8'h66; 8'ha6: r=8'hca; 8'ha7: r=8'h60;
            8'ha8: r=8'hc0; 8'ha9: r=8'h29; 8'haa: r=8'h23; 8'hab: r=8'hab;
            8'hac: r=8'h0d; 8'had: r=8'h53; 8'hae: r=8'h4e; 8'haf: r=8'h6f;
            8'hb0: r=8'hd5; 8'hb1: r=8'hdb; 8'hb2: r=8'h37; 8'hb3: r=8'h45;
            8'hb4: r=8'hde; 8'hb5: r=8'hfd; 8'hb6: r=8'h8e; 8'hb7: r=8'h2f;
            8'hb8: r=8'h03; 8'hb9: r=8'hff; 8'hba: r=8'h6a; 8'hbb: r=8'h72;
            8'hbc: r=8'h6d; 8'hbd: r=8'h6c; 8'hbe: r=8'h5b; 8'hbf: r=8'h51;
            8'hc0: r=8'h8d; 8'hc1: r=8'h1b; 8'hc2: r=8'haf; 8'hc3: r=8'h92;
            8'hc4: r=8'hbb; 8'hc5: r=8'hdd; 8'hc6: r=8'hbc; 8'hc7: r=8'h7f;
            8'hc8: r=8'h11; 8'hc9: r=8'hd9; 8'hca: r=8'h5c; 8'hcb: r=8'h41;
            8'hcc: r=8'h1f; 8'hcd: r=8'h10; 8'hce: r=8'h5a; 8'hcf: r=8'hd8;
            8'hd0: r=8'h0a; 8'hd1: r=8'hc1; 8'hd2: r=8'h31; 8'hd3: r=8'h88;
            8'hd4: r=8'ha5; 8'hd5: r=8'hcd; 8'hd6: r=8'h7b; 8'hd7: r=8'hbd;
            8'hd8: r=8'h2d; 8'hd9: r=8'h74; 8'hda: r=8'hd0; 8'hdb: r=8'h12;
            8'hdc: r=8'hb8; 8'hdd: r=8'he5; 8'hde: r=8'hb4; 8'hdf: r=8'hb0;
            8'he0: r=8'h89; 8'he1: r=8'h69; 8'he2: r=8'h97; 8'he3: r=8'h4a;
            8'he4: r=8'h0c; 8'he5: r=8'h96; 8'he6: r=8'h77; 8'he7: r=8'h7e;
            8'he8: r=8'h65; 8'he9: r=8'hb9; 8'hea: r=8'hf1; 8'heb: r=8'h09;
            8'hec: r=8'hc5; 8'hed: r=8'h6e; 8'hee: r=8'hc6; 8'hef: r=8'h84;
            8'hf0: r=8'h18; 8'hf1: r=8'hf0; 8'hf2: r=8'h7d; 8'hf3: r=8'hec;
            8'hf4: r=8'h3a; 8'hf5: r=8'hdc; 8'hf6: r=8'h4d; 8'hf7: r=8'h20;
            8'hf8: r=8'h79; 8'hf9: r=8'hee; 8'hfa: r=8'h5f; 8'hfb: r=8'h3e;
            8'hfc: r=8'hd7; 8'hfd: r=8'hcb; 8'hfe: r=8'h39; 8'hff: r=8'h48;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    function automatic logic [31:0] rotl(input logic [31:0] v, input int n);
        return (v << n) | (v >> (32 - n));
    endfunction

    // Byte substitution then linear diffusion of one round
    function automatic logic [31:0] round_fn(input logic [31:0] a);
        logic [31:0] t;
        t = {sbox(a[31:24]), sbox(a[23:16]), sbox(a[15:8]), sbox(a[7:0])};
        return t ^ rotl(t, 2) ^ rotl(t, 10) ^ rotl(t, 18) ^ rotl(t, 24);
    endfunction
endpackage
`default_nettype wire

[rtl/core/sm4_if.sv]
// Valid/ready channel interfaces for the SM4 core.
// Depends on nothing.
`default_nettype none
interface sm4_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [4:0]  key_index;
    logic [31:0] key_word;
    logic [63:0] block_in_high;
    logic [63:0] block_in_low;
    modport source (output valid, kind, key_index, key_word, block_in_high, block_in_low,
                    input ready);
    modport sink   (input valid, kind, key_index, key_word, block_in_high, block_in_low,
                    output ready);
endinterface

interface sm4_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] block_out_high;
    logic [63:0] block_out_low;
    modport source (output valid, block_out_high, block_out_low, input ready);
    modport sink   (input valid, block_out_high, block_out_low, output ready);
endinterface
`default_nettype wire

[rtl/core/sm4_round_stage.sv]
// One pipelined SM4 round with its own round-key register.
// Depends on sm4_pkg.
`default_nettype none
module sm4_round_stage
    import sm4_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_key_we,
    input  wire logic [31:0] i_key_word,
    input  wire logic [31:0] i_key_alt,
    input  wire logic        i_en,
    input  wire logic        i_valid,
    input  wire t_state      i_state,
    output logic             o_valid,
    output t_state           o_state,
    output logic [31:0]      o_key
);
    logic [31:0] r_key;
    logic        r_valid;
    t_state      r_state;
    t_state      n_state;
    logic [31:0] n_k;

    // hold this round's key
    always_ff @(posedge i_clk) begin
        if (i_key_we) begin
            r_key <= i_key_word;
        end
    end

    // pick encrypt or decrypt key, apply round
    always_comb begin
        n_k        = i_state.dec ? i_key_alt : r_key;
        n_state.dec = i_state.dec;
        n_state.x0 = i_state.x1;
        n_state.x1 = i_state.x2;
        n_state.x2 = i_state.x3;
        n_state.x3 = i_state.x0 ^ round_fn(i_state.x1 ^ i_state.x2 ^ i_state.x3 ^ n_k);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_state <= n_state;
        end
    end

    assign o_valid = r_valid;
    assign o_state = r_state;
    assign o_key   = r_key;
endmodule
`default_nettype wire

[rtl/core/sm4_block_cipher_core.sv]
// SM4 cipher top level: 32-stage round pipeline with output register.
// Depends on sm4_pkg, sm4_if and sm4_round_stage.
`default_nettype none
// One block enters per cycle while the pipe is not stalled; a taken block passes
// one register per round, then the output register. Each round stage keeps its
// own key word, so key loads are written into the stage directly; a key load is
// held off until no block is left in the pipe or the output register, so every
// block sees the keys loaded before it. A full output stalls the whole pipe.
module sm4_block_cipher_core
    import sm4_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    sm4_in_if.sink    i_in,
    sm4_out_if.source o_out
);
    logic        w_en;
    logic        w_valid [ROUNDS+1];
    t_state      w_state [ROUNDS+1];
    logic [31:0] w_key   [ROUNDS];
    logic        w_is_blk;
    logic        w_is_load;
    logic        w_busy;
    logic        w_acc;
    logic        r_out_valid;
    logic [63:0] r_hi;
    logic [63:0] r_lo;
    t_state      w_last;

    // flag any block still in the pipe or the output register
    always_comb begin
        w_busy = r_out_valid;
        for (int i = 1; i <= ROUNDS; i++) begin
            w_busy = w_busy | w_valid[i];
        end
    end

    // advance when the output slot is free or drains this cycle
    assign w_en      = !r_out_valid || o_out.ready;
    assign w_is_load = (i_in.kind == KIND_LOAD);
    assign i_in.ready = w_en && !(w_is_load && w_busy);
    assign w_acc     = i_in.valid && i_in.ready;
    assign w_is_blk  = (i_in.kind == KIND_ENC) || (i_in.kind == KIND_DEC);

    assign w_valid[0]    = i_in.valid && w_is_blk;
    assign w_state[0].dec = (i_in.kind == KIND_DEC);
    assign w_state[0].x0 = i_in.block_in_high[63:32];
    assign w_state[0].x1 = i_in.block_in_high[31:0];
    assign w_state[0].x2 = i_in.block_in_low[63:32];
    assign w_state[0].x3 = i_in.block_in_low[31:0];

    for (genvar g = 0; g < ROUNDS; g++) begin : g_rnd
        sm4_round_stage u_rnd (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_key_we   (w_acc && w_is_load
                         && (i_in.key_index == KEY_AW'(g))),
            .i_key_word (i_in.key_word),
            .i_key_alt  (w_key[ROUNDS-1-g]),
            .i_en       (w_en),
            .i_valid    (w_valid[g]),
            .i_state    (w_state[g]),
            .o_valid    (w_valid[g+1]),
            .o_state    (w_state[g+1]),
            .o_key      (w_key[g])
        );
    end

    assign w_last = w_state[ROUNDS];

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= w_valid[ROUNDS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_hi <= {w_last.x3, w_last.x2};
            r_lo <= {w_last.x1, w_last.x0};
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.block_out_high = r_hi;
    assign o_out.block_out_low  = r_lo;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !o_out.ready |=> r_out_valid && $stable(r_hi) && $stable(r_lo))
        else $error("output lost under stall");
    a_nostall_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_busy |-> i_in.ready)
        else $error("pipe stalled while empty");
    a_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_en && w_valid[ROUNDS] |=> r_out_valid)
        else $error("finished block dropped");
    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc && w_is_load |-> !w_busy)
        else $error("key load taken with blocks in flight");
endmodule
`default_nettype wire

[dv/sm4_block_cipher_core_tb.sv]
// Testbench for the SM4 block cipher core: key loads, encrypt and decrypt transfers.
// Depends on sm4_pkg, sm4_if and sm4_block_cipher_core; holds its own cipher predictor and scoreboard.
`default_nettype none
module sm4_block_cipher_core_tb;
    import sm4_pkg::*;

    localparam int PIPE_LAT   = 33;
    localparam int WDOG_LIMIT = 20000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    sm4_in_if  in_ch();
    sm4_out_if out_ch();

    sm4_block_cipher_core dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch.sink),
        .o_out  (out_ch.source)
    );

    // Invert the clock every half period
    always #10 i_clk = ~i_clk;

    // Cipher S-box, kept apart from the package copy
    localparam logic [7:0] SM4_SBOX [256] = '{
        8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
        8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
        8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
        8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
        8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
        8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
        8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
        8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
        8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
        8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
        8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
        8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
        8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
        8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
        8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
        8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
    };

    logic [31:0]  key_shadow [ROUNDS];
    logic [127:0] cipher_expected [$];
    int           idle_in_pct  = 0;
    int           idle_out_pct = 0;
    int           hold_off     = 0;
    int           fail_cnt     = 0;
    int           blocks_seen  = 0;
    int           loads_sent   = 0;
    int           quiet_cycles = 0;

    function automatic logic [31:0] lrot(logic [31:0] v, int n);
        return (v << n) | (v >> (32 - n));
    endfunction

    // Mix one round: nonlinear byte substitution then the linear diffusion
    function automatic logic [31:0] mix_word(logic [31:0] a);
        logic [31:0] b;
        b = {SM4_SBOX[a[31:24]], SM4_SBOX[a[23:16]], SM4_SBOX[a[15:8]], SM4_SBOX[a[7:0]]};
        return b ^ lrot(b, 2) ^ lrot(b, 10) ^ lrot(b, 18) ^ lrot(b, 24);
    endfunction

    function automatic logic [127:0] cipher_block(t_kind k, logic [127:0] blk);
        logic [31:0] w [4];
        logic [31:0] nw;
        int ki;
        w[0] = blk[127:96]; w[1] = blk[95:64]; w[2] = blk[63:32]; w[3] = blk[31:0];
        for (int r = 0; r < ROUNDS; r++) begin
            ki = (k == KIND_ENC) ? r : ROUNDS - 1 - r;
            nw = w[0] ^ mix_word(w[1] ^ w[2] ^ w[3] ^ key_shadow[ki]);
            w[0] = w[1]; w[1] = w[2]; w[2] = w[3]; w[3] = nw;
        end
        return {w[3], w[2], w[1], w[0]};
    endfunction

    // Offer one transfer, idling at random first, and predict its result;
    // valid stays high after the transfer until the next idle or drain
    task automatic send_item(t_kind k, logic [4:0] idx, logic [31:0] kw, logic [127:0] blk);
        while ($urandom_range(99) < idle_in_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid         <= 1'b1;
        in_ch.kind          <= k;
        in_ch.key_index     <= idx;
        in_ch.key_word      <= kw;
        in_ch.block_in_high <= blk[127:64];
        in_ch.block_in_low  <= blk[63:0];
        do @(posedge i_clk); while (!in_ch.ready);
        if (k == KIND_LOAD) begin
            key_shadow[idx] = kw;
            loads_sent++;
        end else if (k == KIND_ENC || k == KIND_DEC) begin
            cipher_expected.push_back(cipher_block(k, blk));
        end
    endtask

    function automatic logic [127:0] rand_block();
        return {$urandom, $urandom, $urandom, $urandom};
    endfunction

    // Drop valid and wait until every expected result has come
    task automatic drain();
        in_ch.valid <= 1'b0;
        while (cipher_expected.size() != 0) @(posedge i_clk);
        repeat (PIPE_LAT + 4) @(posedge i_clk);
    endtask

    // Load a full key schedule; pipe must be idle
    task automatic load_keys(int pattern);
        logic [31:0] kw;
        drain();
        for (int i = 0; i < ROUNDS; i++) begin
            case (pattern)
                0:       kw = 32'h0;
                1:       kw = 32'hffff_ffff;
                default: kw = $urandom;
            endcase
            send_item(KIND_LOAD, 5'(i), kw, rand_block());
        end
    endtask

    task automatic test_directed();
        logic [127:0] edges [4];
        edges = '{128'h0, {128{1'b1}}, 128'h0123456789abcdeffedcba9876543210,
                  {4{32'h8000_0001}}};
        load_keys(0);
        foreach (edges[i]) send_item(KIND_ENC, 5'd0, 32'h0, edges[i]);
        load_keys(1);
        foreach (edges[i]) send_item(KIND_DEC, 5'd31, 32'hffff_ffff, edges[i]);
        // Unused kind must leave no trace
        send_item(KIND_NONE, 5'd3, 32'hdead_beef, {128{1'b1}});
        send_item(KIND_ENC, 5'd0, 32'h0, 128'h0);
    endtask

    task automatic test_random(int n);
        int pick;
        for (int i = 0; i < n; i++) begin
            if (i % 100 == 50) load_keys(2);
            pick = $urandom_range(19);
            if (pick == 0)
                send_item(KIND_NONE, 5'($urandom), $urandom, rand_block());
            else
                send_item(pick[0] ? KIND_ENC : KIND_DEC, 5'($urandom), $urandom,
                          rand_block());
        end
    endtask

    // Hold the output off while blocks keep coming, so the pipe backs up
    task automatic test_backpressure();
        hold_off = 200;
        for (int i = 0; i < 60; i++)
            send_item(i[0] ? KIND_ENC : KIND_DEC, 5'd0, 32'h0, rand_block());
        drain();
    endtask

    // Drive the output ready
    always @(posedge i_clk) begin
        if (hold_off > 0) begin
            hold_off     <= hold_off - 1;
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= ($urandom_range(99) >= idle_out_pct);
        end
    end

    // Compare each result transfer with the oldest prediction
    always @(posedge i_clk) begin
        logic [127:0] exp_blk;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            blocks_seen++;
            if (cipher_expected.size() == 0) begin
                $display("%0t: unexpected block %h_%h", $time,
                         out_ch.block_out_high, out_ch.block_out_low);
                fail_cnt++;
            end else begin
                exp_blk = cipher_expected.pop_front();
                if (out_ch.block_out_high !== exp_blk[127:64]) begin
                    $display("%0t: block_out_high expected %h actual %h", $time,
                             exp_blk[127:64], out_ch.block_out_high);
                    fail_cnt++;
                end
                if (out_ch.block_out_low !== exp_blk[63:0]) begin
                    $display("%0t: block_out_low expected %h actual %h", $time,
                             exp_blk[63:0], out_ch.block_out_low);
                    fail_cnt++;
                end
            end
        end
    end

    // Watchdog: count cycles without any transfer
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > WDOG_LIMIT) begin
            $display("watchdog expired with %0d blocks outstanding", cipher_expected.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        in_ch.valid         = 1'b0;
        in_ch.kind          = KIND_NONE;
        in_ch.key_index     = '0;
        in_ch.key_word      = '0;
        in_ch.block_in_high = '0;
        in_ch.block_in_low  = '0;
        out_ch.ready        = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        idle_in_pct = 8;  idle_out_pct = 61;
        test_random(180);
        test_backpressure();
        idle_in_pct = 61; idle_out_pct = 8;
        test_random(180);
        idle_in_pct = 0;  idle_out_pct = 0;
        test_random(180);
        drain();

        $display("covered %0d key loads and %0d checked blocks, all-zero and all-one keys,",
                 loads_sent, blocks_seen);
        $display("random schedules, unused kind, long output stall and three idle mixes");
        if (fail_cnt == 0 && cipher_expected.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
`default_nettype wire

[sm4_block_cipher_core.f]
rtl/core/sm4_pkg.sv
rtl/core/sm4_if.sv
rtl/core/sm4_round_stage.sv
rtl/core/sm4_block_cipher_core.sv
dv/sm4_block_cipher_core_tb.sv
